### src/lzw_pkg.sv
// ----------------------------------------------------------------------------
// lzw_pkg: shared types and constants for the LZW byte compressor
// Controller states, command and status bundles, fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package lzw_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned OutCodeW = 12;
  localparam int unsigned FirstFree = 256;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT_MISS,
    ST_EMIT_LAST
  } lzw_state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;      // input word taken this cycle
    logic start_scan;  // begin dictionary scan at first free code
    logic scan_en;     // scan running
    logic take_hit;    // prefix becomes matched code
    logic emit_miss;   // emit prefix, add pair, restart from byte
    logic emit_last;   // emit final prefix, clear dictionary
  } lzw_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic prefix_valid;
    logic dict_empty;
    logic hit;
    logic miss_done;
    logic slot_free;
    logic last_q;
  } lzw_status_t;

endpackage

`default_nettype wire

### src/lzw_stream_if.sv
// ----------------------------------------------------------------------------
// lzw_stream_if: byte and code channels
// Valid/ready channels carrying input bytes and output codes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lzw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface lzw_code_if;
  logic        valid;
  logic        ready;
  logic [11:0] code_word;
  logic        code_last;

  modport source (output valid, output code_word, output code_last, input ready);
  modport sink   (input valid, input code_word, input code_last, output ready);
endinterface

`default_nettype wire

### src/lzw_ram.sv
// ----------------------------------------------------------------------------
// lzw_ram: generic single-port RAM
// One read or write address per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

### src/lzw_ctrl.sv
// ----------------------------------------------------------------------------
// lzw_ctrl: LZW sequencing controller
// Accepts a byte, runs the dictionary scan, and sequences code output.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_last_i,
  output logic                      in_ready_o,
  input  wire lzw_pkg::lzw_status_t status_i,
  output lzw_pkg::lzw_cmd_t         cmd_o
);
  import lzw_pkg::*;

  lzw_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (!status_i.prefix_valid) begin
            if (in_last_i) state_d = ST_EMIT_LAST;
          end else if (status_i.dict_empty) begin
            state_d = ST_EMIT_MISS;
          end else begin
            cmd_o.start_scan = 1'b1;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (status_i.hit) begin
          cmd_o.take_hit = 1'b1;
          state_d = status_i.last_q ? ST_EMIT_LAST : ST_IDLE;
        end else if (status_i.miss_done) begin
          state_d = ST_EMIT_MISS;
        end
      end
      ST_EMIT_MISS: begin
        if (status_i.slot_free) begin
          cmd_o.emit_miss = 1'b1;
          state_d = status_i.last_q ? ST_EMIT_LAST : ST_IDLE;
        end
      end
      ST_EMIT_LAST: begin
        if (status_i.slot_free) begin
          cmd_o.emit_last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### src/lzw_dp.sv
// ----------------------------------------------------------------------------
// lzw_dp: LZW datapath
// Prefix and free-code registers, dictionary RAM with a pipelined scan,
// and the output code register.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_dp #(
  parameter int unsigned CODE_BITS = 12
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [7:0]           in_byte_i,
  input  wire logic                 in_last_i,
  input  wire lzw_pkg::lzw_cmd_t    cmd_i,
  output lzw_pkg::lzw_status_t      status_o,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output logic [11:0]               out_code_o,
  output logic                      out_last_o
);
  import lzw_pkg::*;

  localparam int unsigned EntryW = CODE_BITS + ByteW;
  localparam int unsigned Depth  = 2 ** CODE_BITS;
  localparam logic [CODE_BITS:0] FirstCode = (CODE_BITS + 1)'(FirstFree);

  logic [CODE_BITS-1:0] prefix_q;
  logic                 prefix_valid_q;
  logic [CODE_BITS:0]   next_free_q;
  logic [ByteW-1:0]     byte_q;
  logic                 last_q;
  logic [CODE_BITS:0]   scan_q;
  logic                 cmp_v_q;
  logic [CODE_BITS-1:0] cmp_addr_q;
  logic                 out_valid_q;
  logic [11:0]          out_code_q;
  logic                 out_last_q;

  logic                 issue;
  logic                 ram_we;
  logic [CODE_BITS-1:0] ram_addr;
  logic [EntryW-1:0]    ram_rdata;
  logic                 match;
  logic [CODE_BITS:0]   last_entry;
  logic [11:0]          prefix_out;

  // scan issues one read per cycle up to the last used code
  assign issue      = cmd_i.scan_en && (scan_q < next_free_q);
  assign ram_we     = cmd_i.emit_miss && !next_free_q[CODE_BITS];
  assign ram_addr   = ram_we ? next_free_q[CODE_BITS-1:0] : scan_q[CODE_BITS-1:0];
  assign match      = (ram_rdata == {prefix_q, byte_q});
  assign last_entry = next_free_q - 1'b1;

  if (CODE_BITS >= 12) begin : g_out_trunc
    assign prefix_out = prefix_q[11:0];
  end else begin : g_out_ext
    assign prefix_out = {{(12 - CODE_BITS){1'b0}}, prefix_q};
  end

  lzw_ram #(
    .WIDTH(EntryW),
    .DEPTH(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i({prefix_q, byte_q}),
    .rdata_o(ram_rdata)
  );

  // status to controller
  always_comb begin
    status_o.prefix_valid = prefix_valid_q;
    status_o.dict_empty   = (next_free_q == FirstCode);
    status_o.hit          = cmp_v_q && match;
    status_o.miss_done    = cmp_v_q && !match &&
                            ({1'b0, cmp_addr_q} == last_entry);
    status_o.slot_free    = !out_valid_q || out_ready_i;
    status_o.last_q       = last_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_valid_q <= 1'b0;
      next_free_q    <= FirstCode;
      cmp_v_q        <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      cmp_v_q <= issue;
      if (cmd_i.accept) prefix_valid_q <= 1'b1;
      if (ram_we) next_free_q <= next_free_q + 1'b1;
      if (cmd_i.emit_last) begin
        prefix_valid_q <= 1'b0;
        next_free_q    <= FirstCode;
      end
      if (cmd_i.emit_miss || cmd_i.emit_last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= in_byte_i;
      last_q <= in_last_i;
      if (!prefix_valid_q) prefix_q <= {{(CODE_BITS - ByteW){1'b0}}, in_byte_i};
    end
    if (cmd_i.start_scan) scan_q <= FirstCode;
    else if (issue) scan_q <= scan_q + 1'b1;
    cmp_addr_q <= scan_q[CODE_BITS-1:0];
    if (cmd_i.take_hit) prefix_q <= cmp_addr_q;
    if (cmd_i.emit_miss) begin
      out_code_q <= prefix_out;
      out_last_q <= 1'b0;
      prefix_q   <= {{(CODE_BITS - ByteW){1'b0}}, byte_q};
    end
    if (cmd_i.emit_last) begin
      out_code_q <= prefix_out;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_code_o  = out_code_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

### src/lzw_byte_compressor_unit.sv
// ----------------------------------------------------------------------------
// lzw_byte_compressor_unit: LZW compressor, bytes in, codes out
// Controller plus datapath with a single-port dictionary RAM.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload                    Accepted when
// byte_i   in   data_byte, end_of_data     valid && ready
// code_o   out  code_word, code_last       valid && ready
//
// A byte needs no scan when it starts a stream or the dictionary is empty; else the
// scan reads codes from 256 up to the last used one: registered RAM read, then one compare a cycle.
// A miss then goes through an emit step, and a last byte through one more.
// Reset clears the prefix-valid flag and the free-code count; the RAM is not cleared.
// A stalled code output holds the block in its emit step.
`default_nettype none

module lzw_byte_compressor_unit #(
  parameter int unsigned CODE_BITS = 12
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lzw_byte_if.sink  byte_i,
  lzw_code_if.source code_o
);
  import lzw_pkg::*;

  lzw_cmd_t    cmd;
  lzw_status_t status;

  lzw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(byte_i.valid),
    .in_last_i (byte_i.end_of_data),
    .in_ready_o(byte_i.ready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  lzw_dp #(
    .CODE_BITS(CODE_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_byte_i  (byte_i.data_byte),
    .in_last_i  (byte_i.end_of_data),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_ready_i(code_o.ready),
    .out_valid_o(code_o.valid),
    .out_code_o (code_o.code_word),
    .out_last_o (code_o.code_last)
  );

endmodule

`default_nettype wire

### dv/lzw_byte_compressor_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_byte_compressor_unit_test: self-checking bench for the LZW compressor
// Drives byte streams and predicts every LZW code with a behavioral
// dictionary. Output codes are compared in order. Streams are short
// repetitive runs, plus noise and a few long runs. Valid and ready are
// throttled in several idle phases.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_byte_compressor_unit_test;

  localparam int unsigned CodeBits = 12;
  localparam int unsigned DictSize = 1 << CodeBits;

  typedef struct packed {
    logic [lzw_pkg::OutCodeW-1:0] code;
    logic                         last;
  } code_word_t;

  typedef struct {
    logic [7:0]  data;
    logic        eod;
    logic        chk;   // typed-in final code applies
    logic [11:0] code;
  } byte_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lzw_byte_if byte_ch ();
  lzw_code_if code_ch ();

  lzw_byte_compressor_unit #(.CODE_BITS(CodeBits)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_ch.sink),
    .code_o (code_ch.source)
  );

  always #4 clk_i = ~clk_i;

  // Behavioral dictionary state
  logic [CodeBits-1:0] dict_prefix [DictSize];
  logic [7:0]          dict_byte   [DictSize];
  logic [CodeBits-1:0] cur_prefix;
  logic                have_prefix;
  int unsigned         free_code;

  code_word_t  expected_codes[$];
  int          fail_count;
  int          bytes_sent;
  int          codes_seen;
  int unsigned idle_phase;   // 0 none, 1 sender, 2 receiver, 3 both

  // Append one expected code word to the queue
  function automatic void queue_code(logic [11:0] code, logic last);
    code_word_t w;
    w.code = code;
    w.last = last;
    expected_codes = {expected_codes, w};
  endfunction

  // Apply one accepted byte to the dictionary and queue the resulting codes
  function automatic void compress_byte(logic [7:0] b, logic eod);
    int unsigned c;
    int unsigned hit;
    hit = DictSize;
    if (!have_prefix) begin
      cur_prefix  = CodeBits'(b);
      have_prefix = 1'b1;
    end else begin
      for (c = lzw_pkg::FirstFree; c < free_code; c++) begin
        if (dict_prefix[c] == cur_prefix && dict_byte[c] == b) begin
          hit = c;
          break;
        end
      end
      if (hit < DictSize) begin
        cur_prefix = CodeBits'(hit);
      end else begin
        queue_code(cur_prefix[11:0], 1'b0);
        if (free_code < DictSize) begin
          dict_prefix[free_code] = cur_prefix;
          dict_byte[free_code]   = b;
          free_code++;
        end
        cur_prefix = CodeBits'(b);
      end
    end
    if (eod) begin
      queue_code(cur_prefix[11:0], 1'b1);
      cur_prefix  = '0;
      have_prefix = 1'b0;
      free_code   = lzw_pkg::FirstFree;
    end
  endfunction

  // Send one word, holding valid across back-to-back words
  task automatic send_byte(logic [7:0] b, logic eod);
    while ((idle_phase == 1 && $urandom_range(0, 99) < 82) ||
           (idle_phase == 3 && $urandom_range(0, 99) < 17)) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_ch.valid       <= 1'b1;
    byte_ch.data_byte   <= b;
    byte_ch.end_of_data <= eod;
    do @(posedge clk_i); while (!byte_ch.ready);
    compress_byte(b, eod);
    bytes_sent++;
  endtask

  // Receiver throttling
  always @(posedge clk_i) begin
    case (idle_phase)
      2: code_ch.ready <= ($urandom_range(0, 99) >= 82);
      3: code_ch.ready <= ($urandom_range(0, 99) >= 17);
      default: code_ch.ready <= 1'b1;
    endcase
  end

  // Output checker
  always @(posedge clk_i) begin
    code_word_t exp_w;
    if (rst_ni && code_ch.valid && code_ch.ready) begin
      codes_seen++;
      if (expected_codes.size() == 0) begin
        $error("unexpected code word %0d last %0b", code_ch.code_word, code_ch.code_last);
        fail_count++;
      end else begin
        exp_w = expected_codes.pop_front();
        if (code_ch.code_word !== exp_w.code) begin
          $error("code_word: expected %0d, actual %0d", exp_w.code, code_ch.code_word);
          fail_count++;
        end
        if (code_ch.code_last !== exp_w.last) begin
          $error("code_last: expected %0b, actual %0b", exp_w.last, code_ch.code_last);
          fail_count++;
        end
      end
    end
  end

  // Directed rows: single-byte streams, extremes, repeats, hits and misses
  byte_row_t dir_rows [] = '{
    '{8'h00, 1'b1, 1'b1, 12'd0},
    '{8'hFF, 1'b1, 1'b1, 12'd255},
    '{8'hA5, 1'b1, 1'b1, 12'd165},
    '{8'h41, 1'b0, 1'b0, 12'd0},
    '{8'h41, 1'b0, 1'b0, 12'd0},
    '{8'h41, 1'b0, 1'b0, 12'd0},
    '{8'h41, 1'b1, 1'b0, 12'd0},
    '{8'h00, 1'b0, 1'b0, 12'd0},
    '{8'hFF, 1'b1, 1'b0, 12'd0},
    '{8'h5A, 1'b0, 1'b0, 12'd0},
    '{8'h5A, 1'b1, 1'b1, 12'd90},
    '{8'h12, 1'b0, 1'b0, 12'd0},
    '{8'h34, 1'b0, 1'b0, 12'd0},
    '{8'h12, 1'b0, 1'b0, 12'd0},
    '{8'h34, 1'b0, 1'b0, 12'd0},
    '{8'h12, 1'b0, 1'b0, 12'd0},
    '{8'h34, 1'b0, 1'b0, 12'd0},
    '{8'h12, 1'b0, 1'b0, 12'd0},
    '{8'h34, 1'b1, 1'b0, 12'd0},
    '{8'h80, 1'b0, 1'b0, 12'd0},
    '{8'h7F, 1'b0, 1'b0, 12'd0},
    '{8'h80, 1'b0, 1'b0, 12'd0},
    '{8'h7F, 1'b1, 1'b0, 12'd0}
  };

  // Watchdog
  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [7:0] alphabet [4];
    int         len;
    int         nsym;
    int         k;
    int         streams;
    free_code           = lzw_pkg::FirstFree;
    have_prefix         = 1'b0;
    cur_prefix          = '0;
    fail_count          = 0;
    bytes_sent          = 0;
    codes_seen          = 0;
    streams             = 0;
    idle_phase          = 0;
    byte_ch.valid       = 1'b0;
    byte_ch.data_byte   = '0;
    byte_ch.end_of_data = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part
    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].data, dir_rows[i].eod);
      if (dir_rows[i].chk && expected_codes[$].code !== dir_rows[i].code) begin
        $error("code_word: expected %0d, actual %0d", dir_rows[i].code,
               expected_codes[$].code);
        fail_count++;
      end
    end

    // Random streams, idle phase rotating every six streams
    while (bytes_sent < 1900) begin
      idle_phase = (streams / 6) % 4;
      streams++;
      nsym = $urandom_range(1, 4);
      foreach (alphabet[j]) alphabet[j] = 8'($urandom);
      case ($urandom_range(0, 19))
        0:       len = $urandom_range(150, 300);  // long run, larger dictionary
        1, 2:    len = 1;
        default: len = $urandom_range(2, 30);
      endcase
      for (k = 0; k < len; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_byte(8'($urandom), k == len - 1);  // noise byte
        end else begin
          send_byte(alphabet[$urandom_range(0, nsym - 1)], k == len - 1);
        end
      end
    end
    byte_ch.valid <= 1'b0;

    // Drain
    idle_phase = 0;
    while (expected_codes.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("Sent %0d bytes in %0d random streams plus directed rows; %0d codes checked.",
             bytes_sent, streams, codes_seen);
    if (fail_count == 0 && expected_codes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
